// ===== src/pncs_pkg.sv =====
// ----------------------------------------------------------------------------
// pncs_pkg
// Shared types and constants for the nearest palette color search unit.
// ----------------------------------------------------------------------------
package pncs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int CH_W  = 8;          // bits per color channel
  localparam int RGB_W = 3 * CH_W;   // packed {red, green, blue}
  localparam int IDX_W = 8;          // width of entry_index / nearest_index
  localparam int SUM_W = CH_W + 2;   // sum of three channel differences

  // Running minimum starts above the largest possible sum (3 * 255).
  localparam logic [SUM_W-1:0] SUM_NONE = '1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic clear;   // new query: reset running minimum
    logic valid;   // entry data on the read port belongs to the scan
  } scan_ctl_t;

endpackage

// ===== src/pncs_palette_mem.sv =====
// ----------------------------------------------------------------------------
// pncs_palette_mem
// Palette storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pncs_palette_mem
  import pncs_pkg::*;
#(
  parameter int DEPTH = PALETTE_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [RGB_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [RGB_W-1:0] rdata
);

  logic [RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pncs_scan.sv =====
// ----------------------------------------------------------------------------
// pncs_scan
// Manhattan distance of one palette entry against the query color and
// running minimum tracker (strict less-than, lowest index wins a tie).
// ----------------------------------------------------------------------------
module pncs_scan
  import pncs_pkg::*;
#(
  parameter int AW = $clog2(PALETTE_ENTRIES_DEF)
) (
  input  logic             clk,
  input  scan_ctl_t        ctl,
  input  logic [CH_W-1:0]  q_red,
  input  logic [CH_W-1:0]  q_green,
  input  logic [CH_W-1:0]  q_blue,
  input  logic [RGB_W-1:0] entry,
  input  logic [AW-1:0]    entry_idx,
  output logic [AW-1:0]    best_idx
);

  logic [SUM_W-1:0] best_sum;
  logic [CH_W-1:0]  e_red, e_green, e_blue;
  logic [CH_W-1:0]  d_red, d_green, d_blue;
  logic [SUM_W-1:0] sum;

  assign e_red   = entry[3*CH_W-1:2*CH_W];
  assign e_green = entry[2*CH_W-1:CH_W];
  assign e_blue  = entry[CH_W-1:0];

  assign d_red   = (e_red   > q_red)   ? e_red   - q_red   : q_red   - e_red;
  assign d_green = (e_green > q_green) ? e_green - q_green : q_green - e_green;
  assign d_blue  = (e_blue  > q_blue)  ? e_blue  - q_blue  : q_blue  - e_blue;

  assign sum = SUM_W'(d_red) + SUM_W'(d_green) + SUM_W'(d_blue);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_sum <= SUM_NONE;
      best_idx <= '0;
    end else if (ctl.valid && (sum < best_sum)) begin
      best_sum <= sum;
      best_idx <= entry_idx;
    end
  end

endmodule

// ===== src/palette_nearest_color_search_unit.sv =====
// Timing: a palette write gives no result. A query reads one palette entry
// per cycle, passes a drain state and then strobes done with nearest_index;
// the next item may start in the done cycle.
// Reset (rst, synchronous) returns the sequencer to idle; palette contents
// are not cleared. done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// palette_nearest_color_search_unit
// Palette of RGB entries with a sequential nearest color (L1 distance) scan.
// ----------------------------------------------------------------------------
module palette_nearest_color_search_unit
  import pncs_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  logic [IDX_W-1:0] entry_index,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             done,
  output logic [IDX_W-1:0] nearest_index
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [AW-1:0]    cnt;
  logic [AW-1:0]    rd_idx;
  logic             rd_valid;
  logic [CH_W-1:0]  q_red, q_green, q_blue;
  logic             accept;
  logic             mem_we;
  logic [IW-1:0]    idx_ext;
  logic [RGB_W-1:0] rdata;
  logic [AW-1:0]    best_idx;
  logic [IW-1:0]    best_ext;
  scan_ctl_t        ctl;

  assign busy   = (state == ST_SCAN) || (state == ST_DRAIN);
  assign accept = start && !busy;

  // Writes past the end of the palette are dropped.
  assign idx_ext = IW'(entry_index);
  assign mem_we  = accept && (func == FUNC_WRITE) &&
                   ({1'b0, idx_ext} < (IW + 1)'(PALETTE_ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE, ST_FIN: begin
        if (accept && (func == FUNC_QUERY)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cnt == LAST_ADDR) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FIN;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (accept && (func == FUNC_QUERY)) begin
      cnt     <= '0;
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + AW'(1);
    end
  end

  pncs_palette_mem #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata ({red, green, blue}),
    .re    (state == ST_SCAN),
    .raddr (cnt),
    .rdata (rdata)
  );

  assign ctl.clear = accept && (func == FUNC_QUERY);
  assign ctl.valid = rd_valid;

  pncs_scan #(
    .AW (AW)
  ) u_scan (
    .clk       (clk),
    .ctl       (ctl),
    .q_red     (q_red),
    .q_green   (q_green),
    .q_blue    (q_blue),
    .entry     (rdata),
    .entry_idx (rd_idx),
    .best_idx  (best_idx)
  );

  // Index wraps to 8 bits for palettes larger than 256 entries.
  assign best_ext      = IW'(best_idx);
  assign nearest_index = best_ext[IDX_W-1:0];
  assign done          = (state == ST_FIN);

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DRAIN))
    else $error("result strobe without a completed scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    busy |-> !mem_we)
    else $error("palette write while a scan is reading");

  a_rd_valid_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ((state == ST_SCAN) || (state == ST_DRAIN)))
    else $error("read data flagged valid outside a scan");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_QUERY)) |=> ((state == ST_SCAN) && (cnt == '0)))
    else $error("accepted query did not start a scan at entry zero");

endmodule
